[design/cows_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Command outcome window statistics package
// Shared types, constants and helpers for the outcome window block.
// ---------------------------------------------------------------------------
package cows_pkg;

    // Number of outcomes kept in the ring.
    localparam int WINDOW = 8;

    // Ring pointer and count widths follow from the window depth.
    localparam int WP_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);

    // Outcome kinds and their storage width.
    localparam int KIND_W = 2;
    localparam int KINDS  = 3;
    localparam logic [KIND_W-1:0] OUTCOME_OK        = 2'd0;
    localparam logic [KIND_W-1:0] OUTCOME_REJECT    = 2'd1;
    localparam logic [KIND_W-1:0] OUTCOME_LINK_FAIL = 2'd2;

    // Commands.
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Timestamp and activity window arithmetic.
    localparam int STAMP_W  = 63;
    localparam int MS_W     = 32;
    localparam int LIMIT_W  = 42;
    localparam logic [LIMIT_W-1:0] US_PER_MS = 42'd1000;

    // Result count fields.
    localparam int OUT_CNT_W = 4;
    localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = 4'd15;

    // Register bus.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ACTIVE_WINDOW = 1'b0;

    // One input word.
    typedef struct packed {
        logic               command;
        logic [KIND_W-1:0]  outcome;
        logic [STAMP_W-1:0] now_us;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic [OUT_CNT_W-1:0] ok_cnt;
        logic [OUT_CNT_W-1:0] reject_cnt;
        logic [OUT_CNT_W-1:0] link_fail_cnt;
        logic [OUT_CNT_W-1:0] fail_cnt;
        logic [OUT_CNT_W-1:0] link_fail_run;
        logic                 active;
    } out_word_t;

    // Clamp a count to the four-bit result field.
    function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [CNT_W:0] v);
        logic [OUT_CNT_W-1:0] r;
        if (v > (CNT_W + 1)'(OUT_CNT_MAX)) begin
            r = OUT_CNT_MAX;
        end else begin
            r = OUT_CNT_W'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[design/command_outcome_window_stats.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Command outcome window statistics
// Ring of recent command outcomes with per-kind counts, link failure run
// and an activity flag, reported once per input word.
// ---------------------------------------------------------------------------
// Each input word gives exactly one result word, via the stage one
// registers and then the output register; a new word can be accepted
// every cycle unless the result output is stalled. The first step reads
// the outcome about to be overwritten from the ring memory (registered
// read); the second step updates the counts, writes the new outcome back
// and loads the output register. A record word whose write lands on the
// entry read by the following word is forwarded, so there is no stall.
// No clearing pass is needed after reset: a read entry is only used once
// the ring is full, and then every entry has been written. The activity
// limit (milliseconds times 1000) is computed when the register is written.
module command_outcome_window_stats (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input words
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire cows_pkg::in_word_t                s_data,
    // Result words
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output cows_pkg::out_word_t                    m_data,
    // Register port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cows_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [cows_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [cows_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    // Register port state.
    logic [cows_pkg::MS_W-1:0]    window_ms_reg;
    logic [cows_pkg::LIMIT_W-1:0] limit_reg;
    logic                         reg_write;

    // Handshake and pipeline control.
    logic accept;
    logic advance;
    logic commit;
    logic rd_en;

    // Stage one (memory read in flight).
    logic                           s1_valid_reg;
    logic                           s1_cmd_reg;
    logic [cows_pkg::KIND_W-1:0]    s1_kind_reg;
    logic [cows_pkg::STAMP_W-1:0]   s1_now_reg;
    logic [cows_pkg::WP_W-1:0]      s1_addr_reg;
    logic                           fwd_reg;
    logic [cows_pkg::KIND_W-1:0]    fwd_data_reg;

    // Architectural state.
    logic [cows_pkg::WP_W-1:0]      wp_reg;
    logic [cows_pkg::WP_W-1:0]      wp_next;
    logic [cows_pkg::CNT_W-1:0]     fill_reg;
    logic [cows_pkg::CNT_W-1:0]     fill_next;
    logic [cows_pkg::CNT_W-1:0]     fail_run_reg;
    logic [cows_pkg::CNT_W-1:0]     fail_run_next;
    logic [cows_pkg::CNT_W-1:0]     cnt_reg  [cows_pkg::KINDS];
    logic [cows_pkg::CNT_W-1:0]     cnt_next [cows_pkg::KINDS];
    logic [cows_pkg::STAMP_W-1:0]   stamp_reg;
    logic [cows_pkg::STAMP_W-1:0]   stamp_next;

    // Output register.
    logic                 m_valid_reg;
    cows_pkg::out_word_t  m_data_reg;
    cows_pkg::out_word_t  m_data_next;

    // Ring memory ports.
    logic                         ram_we;
    logic [cows_pkg::KIND_W-1:0]  ram_rdata;
    logic [cows_pkg::KIND_W-1:0]  in_kind;

    // Register port: always ready, one register at word index zero.
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite
                       && (paddr[2] == cows_pkg::REG_ACTIVE_WINDOW);

    always_comb begin
        if (paddr[2] == cows_pkg::REG_ACTIVE_WINDOW) begin
            prdata = window_ms_reg;
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_ms_reg <= '0;
            limit_reg     <= '0;
        end else if (reg_write) begin
            window_ms_reg <= pwdata;
            limit_reg     <= cows_pkg::LIMIT_W'(pwdata) * cows_pkg::US_PER_MS;
        end
    end

    // Pipeline handshake: the output register frees the pipe when taken.
    assign advance = !m_valid_reg || m_ready;
    assign commit  = s1_valid_reg && advance;
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign rd_en   = accept && (s_data.command == cows_pkg::CMD_RECORD);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Outcome code three counts as a link failure.
    assign in_kind = (s_data.outcome > cows_pkg::OUTCOME_LINK_FAIL)
                     ? cows_pkg::OUTCOME_LINK_FAIL : s_data.outcome;

    // Ring write happens when a record word commits.
    assign ram_we = commit && (s1_cmd_reg == cows_pkg::CMD_RECORD);

    // Write pointer moves on to the next entry when a record is accepted.
    always_comb begin
        if (wp_reg == cows_pkg::WP_W'(cows_pkg::WINDOW - 1)) begin
            wp_next = '0;
        end else begin
            wp_next = wp_reg + 1'b1;
        end
    end

    cows_ram #(
        .WIDTH (cows_pkg::KIND_W),
        .DEPTH (cows_pkg::WINDOW),
        .AW    (cows_pkg::WP_W)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (s1_kind_reg),
        .re    (rd_en),
        .raddr (wp_reg),
        .rdata (ram_rdata)
    );

    // Stage one control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            wp_reg       <= '0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (commit) begin
                s1_valid_reg <= 1'b0;
            end
            if (rd_en) begin
                wp_reg <= wp_next;
            end
        end
    end

    // Stage one payload, with forwarding of a same-entry write.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cmd_reg   <= s_data.command;
            s1_kind_reg  <= in_kind;
            s1_now_reg   <= s_data.now_us;
            s1_addr_reg  <= wp_reg;
            fwd_reg      <= ram_we && (s1_addr_reg == wp_reg);
            fwd_data_reg <= s1_kind_reg;
        end
    end

    // Update of counts, run, fill and timestamp, and the result word.
    always_comb begin
        logic                          is_record;
        logic                          full;
        logic [cows_pkg::KIND_W-1:0]   old_kind;
        logic [cows_pkg::CNT_W:0]      total;
        logic [cows_pkg::STAMP_W-1:0]  elapsed;
        logic                          active;

        is_record = (s1_cmd_reg == cows_pkg::CMD_RECORD);
        full      = (fill_reg >= cows_pkg::CNT_W'(cows_pkg::WINDOW));
        old_kind  = fwd_reg ? fwd_data_reg : ram_rdata;
        if (old_kind > cows_pkg::OUTCOME_LINK_FAIL) begin
            old_kind = cows_pkg::OUTCOME_LINK_FAIL;
        end

        fill_next     = fill_reg;
        fail_run_next = fail_run_reg;
        stamp_next    = stamp_reg;
        for (int k = 0; k < cows_pkg::KINDS; k++) begin
            cnt_next[k] = cnt_reg[k];
        end

        if (is_record) begin
            // Retire the overwritten entry once the ring is full.
            if (full) begin
                for (int k = 0; k < cows_pkg::KINDS; k++) begin
                    if ((old_kind == cows_pkg::KIND_W'(k)) && (cnt_reg[k] != '0)) begin
                        cnt_next[k] = cnt_reg[k] - 1'b1;
                    end
                end
            end else begin
                fill_next = fill_reg + 1'b1;
            end
            for (int k = 0; k < cows_pkg::KINDS; k++) begin
                if (s1_kind_reg == cows_pkg::KIND_W'(k)) begin
                    cnt_next[k] = cnt_next[k] + 1'b1;
                end
            end
            // Link failure run grows up to the filled depth.
            if (s1_kind_reg == cows_pkg::OUTCOME_LINK_FAIL) begin
                if (fail_run_reg < fill_next) begin
                    fail_run_next = fail_run_reg + 1'b1;
                end
            end else begin
                fail_run_next = '0;
            end
            if (s1_now_reg != '0) begin
                stamp_next = s1_now_reg;
            end
        end

        // Activity flag against the most recent timestamp.
        elapsed = s1_now_reg - stamp_next;
        active  = (limit_reg != '0) && (stamp_next != '0)
                  && (s1_now_reg >= stamp_next)
                  && (elapsed <= cows_pkg::STAMP_W'(limit_reg));

        total = {1'b0, cnt_next[1]} + {1'b0, cnt_next[2]};

        if (fill_next == '0) begin
            m_data_next = '0;
        end else begin
            m_data_next.ok_cnt        = cows_pkg::sat_count({1'b0, cnt_next[0]});
            m_data_next.reject_cnt    = cows_pkg::sat_count({1'b0, cnt_next[1]});
            m_data_next.link_fail_cnt = cows_pkg::sat_count({1'b0, cnt_next[2]});
            m_data_next.fail_cnt      = cows_pkg::sat_count(total);
            m_data_next.link_fail_run = cows_pkg::sat_count({1'b0, fail_run_next});
            m_data_next.active        = active;
        end
    end

    // State and output register updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            fill_reg     <= '0;
            fail_run_reg <= '0;
            stamp_reg    <= '0;
            for (int k = 0; k < cows_pkg::KINDS; k++) begin
                cnt_reg[k] <= '0;
            end
        end else begin
            if (advance) begin
                m_valid_reg <= s1_valid_reg;
            end
            if (commit) begin
                fill_reg     <= fill_next;
                fail_run_reg <= fail_run_next;
                stamp_reg    <= stamp_next;
                for (int k = 0; k < cows_pkg::KINDS; k++) begin
                    cnt_reg[k] <= cnt_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
`default_nettype wire

[design/cows_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module cows_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while re is low.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[bench/tb_top.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Command outcome window statistics testbench
// Drives record and query words with random idle and stall bursts. A local
// model of the outcome ring, counts, link failure run and activity window
// predicts each result word. Every result is checked field by field, and the
// activity window register is written and read back between phases.
// ---------------------------------------------------------------------------
module tb_top;
    import cows_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ADDR_ACTIVE_WINDOW = {REG_ACTIVE_WINDOW, 2'b00};
    localparam logic [STAMP_W-1:0]    STAMP_MAX          = '1;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_word_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_word_t             m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Local copy of the block's state and register.
    logic [KIND_W-1:0]  ring_kinds [WINDOW];
    int                 ring_wp;
    int                 ring_fill;
    int                 kind_total [KINDS];
    int                 link_run;
    logic [STAMP_W-1:0] last_stamp;
    logic [MS_W-1:0]    window_ms;

    out_word_t expected_stats [$];
    int        mismatch_count;
    bit        idle_on;
    int        stall_left;

    command_outcome_window_stats DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    // Run limit, far above the slowest correct run.
    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic void report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch in %s: expected %h, got %h", what, want, got);
        end
    endfunction

    function automatic logic [OUT_CNT_W-1:0] clamp_count(int v);
        return (v > 15) ? OUT_CNT_MAX : OUT_CNT_W'(v);
    endfunction

    // Apply one word to the local state and work out its statistics.
    function automatic out_word_t window_stats_after(in_word_t w);
        logic [KIND_W-1:0] kind;
        logic [KIND_W-1:0] old;
        logic [63:0]       elapsed;
        logic [63:0]       span;
        out_word_t         r;
        // Code three is counted as a link failure.
        kind = (w.outcome > OUTCOME_LINK_FAIL) ? OUTCOME_LINK_FAIL : w.outcome;
        if (w.command == CMD_RECORD) begin
            if (ring_fill >= WINDOW) begin
                old = ring_kinds[ring_wp];
                if (kind_total[old] > 0) begin
                    kind_total[old]--;
                end
            end else begin
                ring_fill++;
            end
            ring_kinds[ring_wp] = kind;
            kind_total[kind]++;
            ring_wp = (ring_wp + 1) % WINDOW;
            if (kind == OUTCOME_LINK_FAIL) begin
                if (link_run < ring_fill) begin
                    link_run++;
                end
            end else begin
                link_run = 0;
            end
            if (w.now_us != '0) begin
                last_stamp = w.now_us;
            end
        end
        r = '0;
        if (ring_fill != 0) begin
            if (window_ms != '0 && last_stamp != '0 && w.now_us >= last_stamp) begin
                elapsed  = 64'(w.now_us) - 64'(last_stamp);
                span     = 64'(window_ms) * 64'd1000;
                r.active = (elapsed <= span);
            end
            r.ok_cnt        = clamp_count(kind_total[OUTCOME_OK]);
            r.reject_cnt    = clamp_count(kind_total[OUTCOME_REJECT]);
            r.link_fail_cnt = clamp_count(kind_total[OUTCOME_LINK_FAIL]);
            r.fail_cnt      = clamp_count(kind_total[OUTCOME_REJECT]
                                          + kind_total[OUTCOME_LINK_FAIL]);
            r.link_fail_run = clamp_count(link_run);
        end
        return r;
    endfunction

    function automatic in_word_t make_word(logic cmd, logic [KIND_W-1:0] kind,
                                           logic [STAMP_W-1:0] now);
        in_word_t w;
        w.command = cmd;
        w.outcome = kind;
        w.now_us  = now;
        return w;
    endfunction

    // Pick a time near the held stamp so that the activity edge is hit often.
    function automatic logic [STAMP_W-1:0] pick_now();
        logic [63:0] span;
        logic [63:0] off;
        span = 64'(window_ms) * 64'd1000;
        off  = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return STAMP_W'(off);
            2: return last_stamp - STAMP_W'(off % 64'd1000);
            3: return last_stamp + STAMP_W'(span);
            4: return last_stamp + STAMP_W'(span) + 1'b1;
            default: return last_stamp + STAMP_W'(off % (2 * span + 2));
        endcase
    endfunction

    // Send one word, starting from the next falling edge; returns at the
    // rising edge that accepts it.
    task automatic send_word(in_word_t w);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        expected_stats.push_back(window_stats_after(w));
    endtask

    // Drop valid and wait until every result is back and the pipeline is empty.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_stats.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Register write followed by a read back.
    task automatic write_window_ms(logic [MS_W-1:0] ms);
        logic [APB_DATA_W-1:0] readback;
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ACTIVE_WINDOW;
        pwdata  <= ms;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        window_ms = ms;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        psel    <= 1'b1;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== ms) begin
            report_mismatch("activity window read back", 64'(ms), 64'(readback));
        end
    endtask

    // Queries on an empty window report nothing, even with a window set.
    task automatic test_empty_window();
        send_word(make_word(CMD_QUERY, OUTCOME_OK, '0));
        send_word(make_word(CMD_QUERY, 2'd3, STAMP_MAX));
        write_window_ms(32'd5);
        send_word(make_word(CMD_QUERY, OUTCOME_REJECT, 63'd1));
    endtask

    // Every outcome code, the activity edges, a held stamp, wrap of the ring
    // and the extremes of time and window.
    task automatic test_directed_outcomes();
        send_word(make_word(CMD_RECORD, OUTCOME_OK, 63'd1000));
        send_word(make_word(CMD_RECORD, OUTCOME_REJECT, '0));
        send_word(make_word(CMD_RECORD, OUTCOME_LINK_FAIL, 63'd3000));
        send_word(make_word(CMD_RECORD, 2'd3, 63'd3000));
        send_word(make_word(CMD_QUERY, OUTCOME_OK, 63'd8000));
        send_word(make_word(CMD_QUERY, 2'd3, 63'd8001));
        send_word(make_word(CMD_QUERY, OUTCOME_REJECT, 63'd2999));
        send_word(make_word(CMD_RECORD, OUTCOME_OK, 63'd8000));
        repeat (6) send_word(make_word(CMD_RECORD, OUTCOME_LINK_FAIL, '0));
        send_word(make_word(CMD_RECORD, OUTCOME_OK, STAMP_MAX));
        send_word(make_word(CMD_QUERY, OUTCOME_LINK_FAIL, STAMP_MAX));
        write_window_ms(32'hFFFF_FFFF);
        send_word(make_word(CMD_QUERY, OUTCOME_OK, STAMP_MAX));
        send_word(make_word(CMD_RECORD, OUTCOME_LINK_FAIL, 63'd1));
        send_word(make_word(CMD_QUERY, OUTCOME_OK, 63'd4_294_967_296_000));
        send_word(make_word(CMD_QUERY, OUTCOME_OK, 63'd4_294_967_296_001));
        write_window_ms(32'd0);
        send_word(make_word(CMD_QUERY, OUTCOME_OK, 63'd1));
    endtask

    // Runs of link failures of every length, ended by an ok, a reject or a query.
    task automatic test_link_fail_runs(int count);
        int                 sent;
        int                 run_len;
        logic [STAMP_W-1:0] now;
        write_window_ms(32'd1);
        sent = 0;
        now  = 63'd500;
        while (sent < count) begin
            run_len = $urandom_range(0, 12);
            repeat (run_len) begin
                now += $urandom_range(0, 1500);
                send_word(make_word(CMD_RECORD, $urandom_range(0, 1) ? 2'd3 : OUTCOME_LINK_FAIL,
                                    now));
                sent++;
            end
            if ($urandom_range(0, 3) == 0) begin
                send_word(make_word(CMD_QUERY, 2'($urandom), now + $urandom_range(0, 1500)));
            end else begin
                send_word(make_word(CMD_RECORD, 2'($urandom_range(0, 1)), now));
            end
            sent++;
        end
    endtask

    // Random records and queries under one window setting.
    task automatic test_random_traffic(logic [MS_W-1:0] ms, int count);
        write_window_ms(ms);
        repeat (count) begin
            send_word(make_word($urandom_range(0, 3) == 0 ? CMD_QUERY : CMD_RECORD,
                                2'($urandom), pick_now()));
        end
    endtask

    // Result checker: one expectation per accepted result word.
    always @(posedge aclk) begin : check_result
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_stats.size() == 0) begin
                report_mismatch("unexpected result word", '0, 64'(m_data));
            end else begin
                want = expected_stats.pop_front();
                if (m_data.ok_cnt !== want.ok_cnt)
                    report_mismatch("ok_cnt", 64'(want.ok_cnt), 64'(m_data.ok_cnt));
                if (m_data.reject_cnt !== want.reject_cnt)
                    report_mismatch("reject_cnt", 64'(want.reject_cnt),
                                    64'(m_data.reject_cnt));
                if (m_data.link_fail_cnt !== want.link_fail_cnt)
                    report_mismatch("link_fail_cnt", 64'(want.link_fail_cnt),
                                    64'(m_data.link_fail_cnt));
                if (m_data.fail_cnt !== want.fail_cnt)
                    report_mismatch("fail_cnt", 64'(want.fail_cnt),
                                    64'(m_data.fail_cnt));
                if (m_data.link_fail_run !== want.link_fail_run)
                    report_mismatch("link_fail_run",
                                    64'(want.link_fail_run),
                                    64'(m_data.link_fail_run));
                if (m_data.active !== want.active)
                    report_mismatch("active", 64'(want.active), 64'(m_data.active));
            end
        end
    end

    // Receiver stalls in random bursts while idling is enabled.
    always @(negedge aclk) begin
        if (idle_on && stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b1;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        idle_on        = 1'b1;
        stall_left     = 0;
        mismatch_count = 0;
        // Local state matches the block after reset.
        foreach (ring_kinds[i]) ring_kinds[i] = OUTCOME_OK;
        foreach (kind_total[i]) kind_total[i] = 0;
        ring_wp    = 0;
        ring_fill  = 0;
        link_run   = 0;
        last_stamp = '0;
        window_ms  = '0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_window();
        test_directed_outcomes();
        test_link_fail_runs(200);
        test_random_traffic(32'd0, 330);
        test_random_traffic(32'd1, 330);
        test_random_traffic($urandom, 330);
        test_random_traffic(32'hFFFF_FFFF, 330);
        // Last part runs back to back with no idling on either side.
        idle_on = 1'b0;
        test_random_traffic(32'($urandom_range(1, 100)), 200);

        wait_idle();
        repeat (10) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
